// ===== src/lrpe_pkg.sv =====
// ----------------------------------------------------------------------------
// lrpe_pkg
// Token kinds, status codes, LR automaton states and payload structs for the
// shift-reduce expression parser.
// ----------------------------------------------------------------------------
package lrpe_pkg;

    typedef logic [2:0] t_token_kind;
    typedef logic [1:0] t_status;
    typedef logic [3:0] t_lr_state;

    // token kinds
    localparam t_token_kind INT      = 3'd0;
    localparam t_token_kind PLUS     = 3'd1;
    localparam t_token_kind MULT     = 3'd2;
    localparam t_token_kind OPENPAR  = 3'd3;
    localparam t_token_kind CLOSEPAR = 3'd4;
    localparam t_token_kind FIN      = 3'd5;

    // result status
    localparam t_status ST_CONSUMED = 2'd0;
    localparam t_status ST_ACCEPT   = 2'd1;
    localparam t_status ST_SYNTAX   = 2'd2;
    localparam t_status ST_OVERFLOW = 2'd3;

    // LR automaton states
    localparam t_lr_state PS_START   = 4'd0;  // start of an expression
    localparam t_lr_state PS_EXPR    = 4'd1;  // complete E at bottom
    localparam t_lr_state PS_OPEN    = 4'd2;  // after '('
    localparam t_lr_state PS_INT     = 4'd3;  // after integer
    localparam t_lr_state PS_PLUS    = 4'd4;  // after E +
    localparam t_lr_state PS_MULT    = 4'd5;  // after E *
    localparam t_lr_state PS_PAREN_E = 4'd6;  // ( E
    localparam t_lr_state PS_ADD_E   = 4'd7;  // E + E
    localparam t_lr_state PS_MUL_E   = 4'd8;  // E * E
    localparam t_lr_state PS_CLOSE   = 4'd9;  // ( E )

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [31:0] token_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_value;
    } t_out_item;

endpackage

// ===== src/lr_expression_parser_evaluator.sv =====
// ----------------------------------------------------------------------------
// lr_expression_parser_evaluator
// Each token is decided in DECIDE; every reduction then runs EXEC and COMMIT
// and returns to DECIDE. The status is registered once the token is shifted,
// accepted or refused; a held result stalls it. A new token is taken only in IDLE;
// each reduction is a stack memory read, a multiply stage and a write-back.
// Reset: synchronous, active low; empty stack with state 0 on top. Memories
// are not cleared; entry 0 is never written, the start state stands in for it.
// ----------------------------------------------------------------------------
module lr_expression_parser_evaluator #(
    parameter int STACK_DEPTH = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lrpe_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lrpe_pkg::t_out_item o_out_item
);
    import lrpe_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int VW = VALUE_WIDTH;
    localparam int HW = (VW + 1) / 2;
    localparam logic [AW-1:0] SP_MAX = AW'(STACK_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_EXEC   = 4'b0100,
        S_COMMIT = 4'b1000
    } t_fsm;

    typedef enum logic [1:0] {
        ACT_SHIFT  = 2'd0,
        ACT_ACCEPT = 2'd1,
        ACT_SYNTAX = 2'd2,
        ACT_REDUCE = 2'd3
    } t_act;

    typedef enum logic [1:0] {
        RULE_INT   = 2'd0,
        RULE_ADD   = 2'd1,
        RULE_MUL   = 2'd2,
        RULE_PAREN = 2'd3
    } t_rule;

    // control state
    t_fsm            r_fsm, n_fsm;
    logic [AW-1:0]   r_sp, n_sp;
    t_lr_state       r_top_state, n_top_state;
    logic [VW-1:0]   r_top_value, n_top_value;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out_item, n_out_item;

    // token and reduction payload
    t_token_kind     r_kind;
    logic [VW-1:0]   r_tval;
    t_rule           r_rule;
    logic [AW-1:0]   r_base;
    logic            r_base_zero;
    t_lr_state       r_goto;
    logic            r_goto_ok;
    logic [2*HW-1:0] r_p_ll;
    logic [VW-1:0]   r_p_lh, r_p_hl;

    // stack memories
    t_lr_state       state_mem [STACK_DEPTH];
    logic [VW-1:0]   value_mem [STACK_DEPTH];
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_lr_state       mem_wstate;
    logic [VW-1:0]   mem_wvalue;
    logic            rd_en;
    logic [AW-1:0]   rd_vaddr;
    t_lr_state       r_rd_state;
    logic [VW-1:0]   r_rd_value;

    // decision
    t_act            d_act;
    t_lr_state       d_push_state;
    logic [VW-1:0]   d_push_value;
    t_rule           d_rule;
    logic [1:0]      d_n;
    logic [AW-1:0]   d_base;
    logic            follows;
    logic            sp_ge3;

    logic [63:0]     tval_wide;
    logic [63:0]     top_wide;
    t_lr_state       uncovered;
    t_lr_state       goto_state;
    logic            goto_ok;
    logic [VW-1:0]   cross_sum;
    logic [VW-1:0]   mul_val;
    logic [VW-1:0]   red_value;
    logic            out_free;
    logic            emit;
    t_status         emit_status;
    logic            restart;

    assign tval_wide   = 64'(i_in_item.token_value);
    assign top_wide    = 64'(r_top_value);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_fsm == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // LR action for the held token against the cached top of stack
    always_comb begin
        follows = (r_kind == PLUS) || (r_kind == MULT) ||
                  (r_kind == CLOSEPAR) || (r_kind == FIN);
        sp_ge3       = (r_sp >= AW'(3));
        d_act        = ACT_SYNTAX;
        d_push_state = PS_START;
        d_push_value = '0;
        d_rule       = RULE_INT;
        d_n          = 2'd1;
        case (r_top_state)
            PS_START, PS_OPEN, PS_PLUS, PS_MULT: begin
                if (r_kind == INT) begin
                    d_act        = ACT_SHIFT;
                    d_push_state = PS_INT;
                    d_push_value = r_tval;
                end else if (r_kind == OPENPAR) begin
                    d_act        = ACT_SHIFT;
                    d_push_state = PS_OPEN;
                end
            end
            PS_EXPR: begin
                if (r_kind == PLUS) begin
                    d_act        = ACT_SHIFT;
                    d_push_state = PS_PLUS;
                end else if (r_kind == MULT) begin
                    d_act        = ACT_SHIFT;
                    d_push_state = PS_MULT;
                end else if (r_kind == FIN) begin
                    d_act = ACT_ACCEPT;
                end
            end
            PS_INT: begin
                if (follows && r_sp != '0) begin
                    d_act  = ACT_REDUCE;
                    d_rule = RULE_INT;
                    d_n    = 2'd1;
                end
            end
            PS_PAREN_E: begin
                if (r_kind == PLUS) begin
                    d_act        = ACT_SHIFT;
                    d_push_state = PS_PLUS;
                end else if (r_kind == MULT) begin
                    d_act        = ACT_SHIFT;
                    d_push_state = PS_MULT;
                end else if (r_kind == CLOSEPAR) begin
                    d_act        = ACT_SHIFT;
                    d_push_state = PS_CLOSE;
                end
            end
            PS_ADD_E: begin
                if (r_kind == MULT) begin
                    d_act        = ACT_SHIFT;
                    d_push_state = PS_MULT;
                end else if (follows && sp_ge3) begin
                    d_act  = ACT_REDUCE;
                    d_rule = RULE_ADD;
                    d_n    = 2'd3;
                end
            end
            PS_MUL_E: begin
                if (follows && sp_ge3) begin
                    d_act  = ACT_REDUCE;
                    d_rule = RULE_MUL;
                    d_n    = 2'd3;
                end
            end
            PS_CLOSE: begin
                if (follows && sp_ge3) begin
                    d_act  = ACT_REDUCE;
                    d_rule = RULE_PAREN;
                    d_n    = 2'd3;
                end
            end
            default: d_act = ACT_SYNTAX;
        endcase
        d_base   = r_sp - AW'(d_n);
        rd_vaddr = (d_rule == RULE_PAREN) ? r_sp - AW'(1) : r_sp - AW'(2);
    end

    // goto on E from the uncovered state; entry 0 is never written, a base of 0 uses the start state
    always_comb begin
        uncovered  = r_base_zero ? PS_START : r_rd_state;
        goto_ok    = 1'b1;
        goto_state = PS_EXPR;
        case (uncovered)
            PS_START: goto_state = PS_EXPR;
            PS_OPEN:  goto_state = PS_PAREN_E;
            PS_PLUS:  goto_state = PS_ADD_E;
            PS_MULT:  goto_state = PS_MUL_E;
            default:  goto_ok    = 1'b0;
        endcase
    end

    // low VW bits of the product from registered half-width partial products
    assign cross_sum = r_p_lh + r_p_hl;
    assign mul_val   = r_p_ll[VW-1:0] + (cross_sum << HW);

    always_comb begin
        case (r_rule)
            RULE_INT:   red_value = r_top_value;
            RULE_ADD:   red_value = r_rd_value + r_top_value;
            RULE_MUL:   red_value = mul_val;
            RULE_PAREN: red_value = r_rd_value;
            default:    red_value = r_top_value;
        endcase
    end

    // sequencer
    always_comb begin
        n_fsm       = r_fsm;
        n_sp        = r_sp;
        n_top_state = r_top_state;
        n_top_value = r_top_value;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        emit        = 1'b0;
        emit_status = ST_CONSUMED;
        restart     = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_sp + AW'(1);
        mem_wstate  = d_push_state;
        mem_wvalue  = d_push_value;
        rd_en       = 1'b0;
        case (r_fsm)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_fsm = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (d_act)
                    ACT_SHIFT: begin
                        if (out_free) begin
                            emit  = 1'b1;
                            n_fsm = S_IDLE;
                            if (r_sp == SP_MAX) begin
                                emit_status = ST_OVERFLOW;
                                restart     = 1'b1;
                            end else begin
                                emit_status = ST_CONSUMED;
                                mem_we      = 1'b1;
                                n_sp        = r_sp + AW'(1);
                                n_top_state = d_push_state;
                                n_top_value = d_push_value;
                            end
                        end
                    end
                    ACT_ACCEPT: begin
                        if (out_free) begin
                            emit        = 1'b1;
                            emit_status = ST_ACCEPT;
                            restart     = 1'b1;
                            n_fsm       = S_IDLE;
                        end
                    end
                    ACT_REDUCE: begin
                        rd_en = 1'b1;
                        n_fsm = S_EXEC;
                    end
                    default: begin
                        if (out_free) begin
                            emit        = 1'b1;
                            emit_status = ST_SYNTAX;
                            restart     = 1'b1;
                            n_fsm       = S_IDLE;
                        end
                    end
                endcase
            end
            S_EXEC: begin
                n_fsm = S_COMMIT;
            end
            S_COMMIT: begin
                if (r_goto_ok) begin
                    mem_we      = 1'b1;
                    mem_waddr   = r_base + AW'(1);
                    mem_wstate  = r_goto;
                    mem_wvalue  = red_value;
                    n_sp        = r_base + AW'(1);
                    n_top_state = r_goto;
                    n_top_value = red_value;
                    n_fsm       = S_DECIDE;
                end else if (out_free) begin
                    emit        = 1'b1;
                    emit_status = ST_SYNTAX;
                    restart     = 1'b1;
                    n_fsm       = S_IDLE;
                end
            end
            default: n_fsm = S_IDLE;
        endcase

        if (emit) begin
            n_out_valid             = 1'b1;
            n_out_item.status       = emit_status;
            n_out_item.result_value = (emit_status == ST_ACCEPT) ? top_wide[31:0] : '0;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (restart) begin
            n_sp        = '0;
            n_top_state = PS_START;
            n_top_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_sp        <= '0;
            r_top_state <= PS_START;
            r_top_value <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_sp        <= n_sp;
            r_top_state <= n_top_state;
            r_top_value <= n_top_value;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        if (r_fsm == S_IDLE && i_in_valid) begin
            r_kind <= i_in_item.token_kind;
            r_tval <= tval_wide[VW-1:0];
        end
        if (rd_en) begin
            r_rule      <= d_rule;
            r_base      <= d_base;
            r_base_zero <= (d_base == '0);
        end
        if (r_fsm == S_EXEC) begin
            r_goto    <= goto_state;
            r_goto_ok <= goto_ok;
            r_p_ll    <= (2*HW)'(r_rd_value[HW-1:0]) * (2*HW)'(r_top_value[HW-1:0]);
            r_p_lh    <= VW'(r_rd_value[HW-1:0]) * VW'(r_top_value[VW-1:HW]);
            r_p_hl    <= VW'(r_rd_value[VW-1:HW]) * VW'(r_top_value[HW-1:0]);
        end
    end

    // stack memories; reads only in DECIDE, writes in DECIDE or COMMIT,
    // so a read never meets a write to the same entry
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            state_mem[mem_waddr] <= mem_wstate;
            value_mem[mem_waddr] <= mem_wvalue;
        end
        if (rd_en) begin
            r_rd_state <= state_mem[d_base];
            r_rd_value <= value_mem[rd_vaddr];
        end
    end

    a_restart_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_status != ST_CONSUMED) |=> (r_sp == '0 && r_top_state == PS_START))
        else $error("stack not reset after final status");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && rd_en))
        else $error("stack memory read and write in same cycle");

    a_reduce_resumes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_COMMIT && r_goto_ok) |=> (r_fsm == S_DECIDE && r_sp != '0))
        else $error("reduction did not return to decide with nonempty stack");

    a_exec_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_EXEC) |-> (r_sp >= AW'(1)))
        else $error("reduction with empty stack");

endmodule
